/* hdl/ecu_pkg.sv */
// shared types and constants for the enumerative combination unranking block
// no dependencies
`default_nettype none

package ecu_pkg;

  // fixed field widths
  localparam int unsigned RANK_W     = 57;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned STATUS_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_B = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_SYMBOL = 2'd0,
    ST_RANGE  = 2'd1,
    ST_EMPTY  = 2'd2
  } status_t;

  // emitted symbol codes
  localparam logic SYM_A = 1'b0;
  localparam logic SYM_B = 1'b1;

endpackage

`default_nettype wire

/* hdl/enumerative_combination_unrank.sv */
// enumerative combination unranking, top level; uses ecu_pkg and ecu_path_mem
// after reset a fill pass builds the path count memory, each entry in a read state
// then a write state; in_tready low meanwhile; config writes are taken always
// per rank: a range check state, then for each symbol one memory read and
// compare-subtract in S_CMP and an output in S_OUT that holds until out_tready;
// one rank at a time
`default_nettype none

module enumerative_combination_unrank #(
  parameter int unsigned MAX_COUNT = 30
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ecu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ecu_pkg::CNT_W-1:0]         cfg_data,
  // rank input
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [ecu_pkg::IN_DATA_W-1:0]     in_tdata,   // [56:0] rank
  // symbol output
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [ecu_pkg::OUT_DATA_W-1:0]         out_tdata,  // [0] symbol
  output logic                                   out_tlast,
  output logic [ecu_pkg::STATUS_W-1:0]           out_tuser   // [1:0] status
);

  import ecu_pkg::*;

  localparam int unsigned CW = $clog2(MAX_COUNT + 1);
  localparam int unsigned AW = 2 * CW;
  localparam int unsigned PW = 2 * MAX_COUNT;
  localparam int unsigned WW = (PW > RANK_W) ? PW : RANK_W;

  typedef enum logic [2:0] {
    S_FILL_RD,
    S_FILL_WR,
    S_IDLE,
    S_RANGE,
    S_CMP,
    S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] count_a_r, count_b_r;
  logic [CW-1:0]   fi_r, fi_nxt, fj_r, fj_nxt;
  logic [PW-1:0]   left_r, left_nxt;
  logic [CW-1:0]   a_r, a_nxt, b_r, b_nxt;
  logic [WW-1:0]   rank_r, rank_nxt;
  logic            sym_r, sym_nxt, last_r, last_nxt;
  status_t         status_r, status_nxt;

  logic [CW-1:0]   a_clamp, b_clamp;
  logic            wr_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [PW-1:0]   wr_data, rd_data;
  logic [WW-1:0]   pc_ext;
  logic            rank_le;

  // clamp configured counts to the table size
  assign a_clamp = (count_a_r > CNT_W'(MAX_COUNT)) ? CW'(MAX_COUNT) : count_a_r[CW-1:0];
  assign b_clamp = (count_b_r > CNT_W'(MAX_COUNT)) ? CW'(MAX_COUNT) : count_b_r[CW-1:0];

  // path count memory
  ecu_path_mem #(
    .AW (AW),
    .DW (PW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // fill write: pascal rule from the entry above and the one to the left
  assign wr_en   = (state_r == S_FILL_WR);
  assign wr_addr = {fi_r, fj_r};
  always_comb begin
    if (fi_r == '0 && fj_r == '0) begin
      wr_data = PW'(1);
    end else begin
      wr_data = ((fi_r != '0) ? rd_data : '0) + ((fj_r != '0) ? left_r : '0);
    end
  end

  // read address follows the sequencer
  always_comb begin
    unique case (state_r)
      S_FILL_RD, S_FILL_WR: rd_addr = {fi_r - CW'(1), fj_r};
      S_IDLE:               rd_addr = {a_clamp, b_clamp};
      default:              rd_addr = {a_r - CW'(1), b_r};
    endcase
  end

  // shared compare-subtract unit
  assign pc_ext  = WW'(rd_data);
  assign rank_le = (rank_r <= pc_ext);

  // sequencer next state
  always_comb begin
    state_nxt  = state_r;
    fi_nxt     = fi_r;
    fj_nxt     = fj_r;
    left_nxt   = left_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    rank_nxt   = rank_r;
    sym_nxt    = sym_r;
    last_nxt   = last_r;
    status_nxt = status_r;
    unique case (state_r)
      S_FILL_RD: begin
        state_nxt = S_FILL_WR;
      end
      S_FILL_WR: begin
        left_nxt = wr_data;
        if (fj_r == CW'(MAX_COUNT)) begin
          fj_nxt = '0;
          fi_nxt = fi_r + CW'(1);
          if (fi_r == CW'(MAX_COUNT)) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FILL_RD;
          end
        end else begin
          fj_nxt    = fj_r + CW'(1);
          state_nxt = S_FILL_RD;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          a_nxt     = a_clamp;
          b_nxt     = b_clamp;
          rank_nxt  = WW'(in_tdata[RANK_W-1:0]);
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        // rd_data holds the total word count here
        sym_nxt  = SYM_A;
        last_nxt = 1'b1;
        if (rank_r == '0 || !rank_le) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_OUT;
        end else if (a_r == '0 && b_r == '0) begin
          status_nxt = ST_EMPTY;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        status_nxt = ST_SYMBOL;
        priority if (b_r == '0) begin
          sym_nxt = SYM_A;
          a_nxt   = a_r - CW'(1);
        end else if (a_r == '0) begin
          sym_nxt = SYM_B;
          b_nxt   = b_r - CW'(1);
        end else if (rank_le) begin
          sym_nxt = SYM_A;
          a_nxt   = a_r - CW'(1);
        end else begin
          sym_nxt  = SYM_B;
          b_nxt    = b_r - CW'(1);
          rank_nxt = rank_r - pc_ext;
        end
        last_nxt  = (a_nxt == '0) && (b_nxt == '0);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = last_r ? S_IDLE : S_CMP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, fill counters and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_FILL_RD;
      fi_r      <= '0;
      fj_r      <= '0;
      count_a_r <= '0;
      count_b_r <= '0;
    end else begin
      state_r <= state_nxt;
      fi_r    <= fi_nxt;
      fj_r    <= fj_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_COUNT_A) begin
          count_a_r <= cfg_data;
        end
        if (cfg_index == CFG_COUNT_B) begin
          count_b_r <= cfg_data;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    left_r   <= left_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    rank_r   <= rank_nxt;
    sym_r    <= sym_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
  end

  // ports
  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, sym_r};
  assign out_tlast  = last_r;
  assign out_tuser  = status_r;

  // no new rank is taken while a result is pending
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("rank accepted while a result is pending");

  // error and empty results are single, final items
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_SYMBOL) |-> out_tlast)
    else $error("non-symbol result not marked last");

  // after the final item the block returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("block not idle after final item");

  // a symbol result with 'b' never comes when no 'b' was left
  a_sym_b_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && b_r == '0) |=> (out_tvalid && out_tdata[0] == SYM_A))
    else $error("'b' emitted with none left");

endmodule

`default_nettype wire

/* hdl/ecu_path_mem.sv */
// path count memory: one write port, one read port with registered data
// no dependencies
`default_nettype none

module ecu_path_mem #(
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 60
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
